FILE: rtl/core/rcc_pkg.sv
// Package for the ring command consumer: layout constants, codes, word types
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rcc_pkg;

	localparam int ENTRY_COUNT  = 16;
	localparam int HEADER_WORDS = 4;
	localparam int ENTRY_WORDS  = 4;
	localparam int COMMIT_WORD  = 3;
	localparam int MEM_WORDS    = HEADER_WORDS + ENTRY_COUNT * ENTRY_WORDS;
	localparam int MEM_AW       = $clog2(MEM_WORDS);
	localparam int SLOT_W       = $clog2(ENTRY_COUNT);
	localparam int CMD_LSB      = 32;
	localparam int RSVD_LSB     = 40;
	localparam int EPOCH_LSB    = 32;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_BEGIN = 2'd1,
		FN_STOP  = 2'd2,
		FN_POLL  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_DISPATCHED = 3'd1,
		STAT_EMPTY      = 3'd2,
		STAT_RETRY      = 3'd3,
		STAT_FAULT      = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		FLT_NONE             = 4'd0,
		FLT_NOT_STARTED      = 4'd1,
		FLT_DIRTY_CONTROL    = 4'd2,
		FLT_DIRTY_COMMIT     = 4'd3,
		FLT_SESSION_RESET    = 4'd4,
		FLT_CONTROL_ADVANCED = 4'd5,
		FLT_FENCE_EXHAUSTED  = 4'd6,
		FLT_FUTURE_COMMIT    = 4'd7,
		FLT_COMMIT_CHANGED   = 4'd8,
		FLT_RESERVED_BITS    = 4'd9,
		FLT_EPOCH_MISMATCH   = 4'd10,
		FLT_REJECTED         = 4'd11
	} fault_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_B_CTRL,
		S_B_SCAN,
		S_P_CTRL,
		S_P_COMMIT,
		S_P_W0,
		S_P_W1,
		S_P_W2,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_CONS,
		RD_SCAN,
		RD_COMMIT,
		RD_W0,
		RD_W1,
		RD_W2
	} rd_sel_t;

	typedef struct packed {
		func_t       func;
		logic [6:0]  word_addr;
		logic [63:0] word_data;
		logic [31:0] session_epoch;
		logic        sink_ready;
		logic        dispatch_fatal;
	} req_word_t;

	typedef struct packed {
		status_t     status;
		fault_t      fault_code;
		logic [7:0]  command;
		logic [31:0] parameter_res;
		logic [63:0] timestamp;
		logic [31:0] frame;
		logic [31:0] epoch;
		logic [63:0] fence;
	} rsp_word_t;

	typedef struct packed {
		logic    capture;
		logic    item_wr;
		rd_sel_t rd_sel;
		logic    scan_clr;
		logic    scan_inc;
		logic    sess_init;
		logic    act_set;
		logic    act_clr;
		logic    flt_we;
		fault_t  flt_code;
		logic    res_we;
		status_t res_status;
		fault_t  res_fault;
		logic    cap_w0;
		logic    cap_w1;
		logic    dispatch;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		func_t  func;
		logic   active;
		fault_t latched;
		logic   rd_nz;
		logic   cons_ne;
		logic   cons_lt;
		logic   fence_max;
		logic   commit_lt;
		logic   commit_gt;
		logic   scan_last;
		logic   rsvd_bad;
		logic   epoch_bad;
		logic   sink_ready;
		logic   fatal;
	} dp_stat_t;

	function automatic logic [MEM_AW-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
		input int word);
		slot_addr = MEM_AW'(HEADER_WORDS + ENTRY_WORDS * int'(slot) + word);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rcc_req_if.sv
// Input channel of the ring command consumer: valid/ready plus one item word.
// Depends on rcc_pkg.
`default_nettype none

interface rcc_req_if;
	import rcc_pkg::*;

	logic      valid;
	logic      ready;
	req_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rcc_rsp_if.sv
// Result channel of the ring command consumer: valid/ready plus one result word.
// Depends on rcc_pkg.
`default_nettype none

interface rcc_rsp_if;
	import rcc_pkg::*;

	logic      valid;
	logic      ready;
	rsp_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ring_command_consumer.sv
// Top level of the ring command consumer: controller plus datapath.
// Depends on rcc_pkg, rcc_req_if, rcc_rsp_if, rcc_ctrl, rcc_datapath.
//
//   channel   dir  handshake     word
//   req       in   valid/ready   rcc_pkg::req_word_t (func, address, data, epoch, flags)
//   rsp       out  valid/ready   rcc_pkg::rsp_word_t (status, fault, entry fields, fence)
//   cfg       in   cfg_we        cfg_data = consumer word offset
//
// One item at a time: a poll makes up to five reads of the word memory, which
// has one read port, and begin reads one commit word per cycle while it scans.
// A new word is taken while a result waits in the output
// register; a finished item holds until that register frees. Reset clears the
// memory at once through per-word valid bits.
`default_nettype none

module ring_command_consumer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_data,
	rcc_req_if.sink         req,
	rcc_rsp_if.source       rsp
);
	import rcc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rcc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_data (rsp.data)
	);

endmodule

`default_nettype wire

FILE: rtl/core/rcc_datapath.sv
// Datapath: word memory with per-word valid bits, session registers, captured
// item and entry words, result register. Depends on rcc_pkg.
`default_nettype none

module rcc_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_data,
	input  wire rcc_pkg::req_word_t req_data,
	input  wire rcc_pkg::dp_cmd_t  cmd,
	output rcc_pkg::dp_stat_t      stat,
	output rcc_pkg::rsp_word_t     rsp_data
);
	import rcc_pkg::*;

	logic [63:0]       mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;

	req_word_t         item_q;
	logic [1:0]        cons_off_q;
	logic [63:0]       rdata_q;
	logic              rvld_q;
	logic [SLOT_W-1:0] scan_q;
	logic [SLOT_W-1:0] scan_d;
	logic              active_q;
	logic [63:0]       fence_q;
	logic [31:0]       epoch_q;
	fault_t            latched_q;
	status_t           status_q;
	fault_t            fault_q;
	logic [63:0]       w0_q;
	logic [63:0]       w1_q;
	logic [63:0]       w2_q;
	rsp_word_t         rsp_q;
	rsp_word_t         rsp_d;

	logic [63:0]       rdata;
	logic [63:0]       expected;
	logic [SLOT_W-1:0] slot;
	logic [MEM_AW-1:0] raddr;
	logic              wr_en;
	logic [MEM_AW-1:0] wr_addr;
	logic [63:0]       wr_data;
	logic              addr_ok;

	assign rdata    = rvld_q ? rdata_q : '0;
	assign expected = fence_q + 64'd1;
	assign slot     = fence_q[SLOT_W-1:0];
	assign addr_ok  = 32'(item_q.word_addr) < 32'(MEM_WORDS);

	always_comb begin
		if (cmd.scan_clr) begin
			scan_d = '0;
		end else if (cmd.scan_inc) begin
			scan_d = scan_q + SLOT_W'(1);
		end else begin
			scan_d = scan_q;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_SCAN:   raddr = slot_addr(scan_d, COMMIT_WORD);
			RD_COMMIT: raddr = slot_addr(slot, COMMIT_WORD);
			RD_W0:     raddr = slot_addr(slot, 0);
			RD_W1:     raddr = slot_addr(slot, 1);
			RD_W2:     raddr = slot_addr(slot, 2);
			default:   raddr = MEM_AW'(cons_off_q);
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = MEM_AW'(item_q.word_addr);
		wr_data = item_q.word_data;
		if (cmd.item_wr && addr_ok) begin
			wr_en = 1'b1;
		end else if (cmd.dispatch) begin
			wr_en   = 1'b1;
			wr_addr = MEM_AW'(cons_off_q);
			wr_data = expected;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cons_off_q <= '0;
			scan_q     <= '0;
			active_q   <= 1'b0;
			fence_q    <= '0;
			epoch_q    <= '0;
			latched_q  <= FLT_NONE;
		end else begin
			if (cfg_we) begin
				cons_off_q <= cfg_data;
			end
			scan_q <= scan_d;
			if (cmd.sess_init) begin
				fence_q <= '0;
				epoch_q <= item_q.session_epoch;
			end else if (cmd.dispatch) begin
				fence_q <= expected;
			end
			if (cmd.act_clr) begin
				active_q <= 1'b0;
			end else if (cmd.act_set) begin
				active_q <= 1'b1;
			end
			if (cmd.flt_we) begin
				latched_q <= cmd.flt_code;
			end
		end
	end

	always_comb begin
		rsp_d            = '0;
		rsp_d.status     = status_q;
		rsp_d.fault_code = fault_q;
		if (status_q == STAT_DISPATCHED) begin
			rsp_d.command       = w0_q[CMD_LSB+7:CMD_LSB];
			rsp_d.parameter_res = w0_q[31:0];
			rsp_d.timestamp     = w1_q;
			rsp_d.frame         = w2_q[31:0];
			rsp_d.epoch         = w2_q[EPOCH_LSB+31:EPOCH_LSB];
			rsp_d.fence         = fence_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_data;
		end
		if (cmd.res_we) begin
			status_q <= cmd.res_status;
			fault_q  <= cmd.res_fault;
		end
		if (cmd.cap_w0) begin
			w0_q <= rdata;
		end
		if (cmd.cap_w1) begin
			w1_q <= rdata;
		end
		if (cmd.dispatch) begin
			w2_q <= rdata;
		end
		if (cmd.out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_data = rsp_q;

	always_comb begin
		stat.func       = item_q.func;
		stat.active     = active_q;
		stat.latched    = latched_q;
		stat.rd_nz      = rdata != '0;
		stat.cons_ne    = rdata != fence_q;
		stat.cons_lt    = rdata < fence_q;
		stat.fence_max  = &fence_q;
		stat.commit_lt  = rdata < expected;
		stat.commit_gt  = rdata > expected;
		stat.scan_last  = scan_q == SLOT_W'(ENTRY_COUNT - 1);
		stat.rsvd_bad   = rdata[63:RSVD_LSB] != '0;
		stat.epoch_bad  = rdata[EPOCH_LSB+31:EPOCH_LSB] != epoch_q;
		stat.sink_ready = item_q.sink_ready;
		stat.fatal      = item_q.dispatch_fatal;
	end

endmodule

`default_nettype wire

FILE: rtl/core/rcc_ctrl.sv
// Controller: sequences one item at a time through memory reads and checks,
// and owns the input ready and result valid. Depends on rcc_pkg.
`default_nettype none

module rcc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	input  wire rcc_pkg::dp_stat_t stat,
	output rcc_pkg::dp_cmd_t      cmd
);
	import rcc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_vld_q;
	logic   out_free;
	fault_t ns_code;

	function automatic dp_cmd_t with_fault(input dp_cmd_t c, input fault_t f);
		dp_cmd_t r;
		r            = c;
		r.flt_we     = 1'b1;
		r.flt_code   = f;
		r.act_clr    = 1'b1;
		r.res_we     = 1'b1;
		r.res_status = STAT_FAULT;
		r.res_fault  = f;
		return r;
	endfunction

	assign out_free  = !rsp_vld_q || rsp_ready;
	assign ns_code   = (stat.latched == FLT_NONE) ? FLT_NOT_STARTED : stat.latched;
	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_vld_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (req_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (stat.func == FN_BEGIN) begin
					state_d = S_B_CTRL;
				end else if (stat.func == FN_POLL && stat.active) begin
					state_d = S_P_CTRL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_B_CTRL:   state_d = stat.rd_nz ? S_FIN : S_B_SCAN;
			S_B_SCAN:   if (stat.rd_nz || stat.scan_last) state_d = S_FIN;
			S_P_CTRL:   state_d = (stat.cons_ne || stat.fence_max) ? S_FIN : S_P_COMMIT;
			S_P_COMMIT: state_d = (stat.commit_lt || stat.commit_gt) ? S_FIN : S_P_W0;
			S_P_W0:     state_d = stat.rsvd_bad ? S_FIN : S_P_W1;
			S_P_W1:     state_d = S_P_W2;
			S_P_W2:     state_d = S_FIN;
			S_FIN:      if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_NONE;
		cmd.flt_code   = FLT_NONE;
		cmd.res_status = STAT_OK;
		cmd.res_fault  = FLT_NONE;
		unique case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_DECODE: begin
				unique case (stat.func)
					FN_WRITE: begin
						cmd.item_wr = 1'b1;
						cmd.res_we  = 1'b1;
					end
					FN_BEGIN: begin
						cmd.sess_init = 1'b1;
						cmd.act_clr   = 1'b1;
						cmd.flt_we    = 1'b1;
						cmd.rd_sel    = RD_CONS;
					end
					FN_STOP: begin
						cmd.act_clr  = 1'b1;
						cmd.flt_we   = 1'b1;
						cmd.flt_code = ns_code;
						cmd.res_we   = 1'b1;
					end
					default: begin
						if (stat.active) begin
							cmd.rd_sel = RD_CONS;
						end else begin
							cmd = with_fault(cmd, ns_code);
						end
					end
				endcase
			end
			S_B_CTRL: begin
				if (stat.rd_nz) begin
					cmd = with_fault(cmd, FLT_DIRTY_CONTROL);
				end else begin
					cmd.scan_clr = 1'b1;
					cmd.rd_sel   = RD_SCAN;
				end
			end
			S_B_SCAN: begin
				if (stat.rd_nz) begin
					cmd = with_fault(cmd, FLT_DIRTY_COMMIT);
				end else if (stat.scan_last) begin
					cmd.act_set = 1'b1;
					cmd.res_we  = 1'b1;
				end else begin
					cmd.scan_inc = 1'b1;
					cmd.rd_sel   = RD_SCAN;
				end
			end
			S_P_CTRL: begin
				if (stat.cons_ne) begin
					cmd = with_fault(cmd, stat.cons_lt ? FLT_SESSION_RESET
						: FLT_CONTROL_ADVANCED);
				end else if (stat.fence_max) begin
					cmd = with_fault(cmd, FLT_FENCE_EXHAUSTED);
				end else begin
					cmd.rd_sel = RD_COMMIT;
				end
			end
			S_P_COMMIT: begin
				if (stat.commit_lt) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = STAT_EMPTY;
				end else if (stat.commit_gt) begin
					cmd = with_fault(cmd, FLT_FUTURE_COMMIT);
				end else begin
					cmd.rd_sel = RD_W0;
				end
			end
			S_P_W0: begin
				cmd.cap_w0 = 1'b1;
				if (stat.rsvd_bad) begin
					cmd = with_fault(cmd, FLT_RESERVED_BITS);
				end else begin
					cmd.rd_sel = RD_W1;
				end
			end
			S_P_W1: begin
				cmd.cap_w1 = 1'b1;
				cmd.rd_sel = RD_W2;
			end
			S_P_W2: begin
				if (stat.epoch_bad) begin
					cmd = with_fault(cmd, FLT_EPOCH_MISMATCH);
				end else if (!stat.sink_ready) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = STAT_RETRY;
				end else if (stat.fatal) begin
					cmd = with_fault(cmd, FLT_REJECTED);
				end else begin
					cmd.dispatch   = 1'b1;
					cmd.res_we     = 1'b1;
					cmd.res_status = STAT_DISPATCHED;
				end
			end
			S_FIN: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
